[rtl/core/mabe_pkg.sv]
package mabe_pkg;

  // Widths of the pixel payload.
  localparam int PIXEL_W = 32;
  localparam int MASK_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int LANES   = PIXEL_W / BYTE_W;

  // Widths of the configuration registers and of the emitted indices.
  localparam int COORD_W   = 12;
  localparam int CFG_DIM_W = 13;
  localparam int IDX_W     = 25;

  // Configuration port geometry.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // Default largest rectangle side.
  localparam int MAX_DIM_DEF = 4096;

  // Blend constants: full weight and the mask codes with special meaning.
  localparam logic [BYTE_W:0]   BLEND_ONE = 9'd256;
  localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hff;
  localparam logic [MASK_W-1:0] MASK_SKIP = 8'h00;
  localparam logic [MASK_W-1:0] MASK_COPY = 8'hff;

  // Register map, word index on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_X        = 3'd0,
    REG_SRC_Y        = 3'd1,
    REG_DST_X        = 3'd2,
    REG_DST_Y        = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_SOURCE_PITCH = 3'd6,
    REG_SCREEN_WIDTH = 3'd7
  } reg_idx_t;

endpackage

[rtl/core/mabe_blend.sv]
module mabe_blend
  import mabe_pkg::*;
(
  input  logic [PIXEL_W-1:0] source_pixel,
  input  logic [MASK_W-1:0]  mask_level,
  input  logic [PIXEL_W-1:0] screen_pixel,
  output logic [PIXEL_W-1:0] new_pixel,
  output logic               write_enable
);

  logic [PIXEL_W-1:0] mixed;
  logic [BYTE_W:0]    inv_weight;

  // The screen byte is weighted by the complement of the mask.
  assign inv_weight = BLEND_ONE - {1'b0, mask_level};

  // Each of the four bytes is blended on its own lane.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [BYTE_W-1:0]     s_byte;
    logic [BYTE_W-1:0]     d_byte;
    logic [2*BYTE_W-1:0]   s_prod;
    logic [2*BYTE_W:0]     d_prod;
    logic [BYTE_W+1:0]     total;

    assign s_byte = source_pixel[g*BYTE_W +: BYTE_W];
    assign d_byte = screen_pixel[g*BYTE_W +: BYTE_W];
    assign s_prod = (2*BYTE_W)'(s_byte) * (2*BYTE_W)'(mask_level);
    assign d_prod = (2*BYTE_W+1)'(d_byte) * (2*BYTE_W+1)'(inv_weight);
    assign total  = (BYTE_W+2)'(s_prod[2*BYTE_W-1:BYTE_W])
                  + (BYTE_W+2)'(d_prod[2*BYTE_W:BYTE_W]);

    // Saturate the sum of the two weighted parts.
    assign mixed[g*BYTE_W +: BYTE_W] =
      (total > (BYTE_W+2)'(BYTE_MAX)) ? BYTE_MAX : total[BYTE_W-1:0];
  end

  // A clear mask keeps the screen word, a solid mask copies the source.
  always_comb begin
    if (mask_level == MASK_SKIP) begin
      new_pixel    = screen_pixel;
      write_enable = 1'b0;
    end else if (mask_level == MASK_COPY) begin
      new_pixel    = source_pixel;
      write_enable = 1'b1;
    end else begin
      new_pixel    = mixed;
      write_enable = 1'b1;
    end
  end

endmodule

[rtl/core/mabe_index.sv]
module mabe_index
  import mabe_pkg::*;
#(
  parameter int SUM_W = COORD_W + 1
)
(
  input  logic [SUM_W-1:0]     row_sum,
  input  logic [SUM_W-1:0]     col_sum,
  input  logic [CFG_DIM_W-1:0] pitch,
  output logic [IDX_W-1:0]     index
);

  localparam int PROD_W = SUM_W + CFG_DIM_W;
  localparam int TOT_W  = PROD_W + 1;

  logic [PROD_W-1:0] row_base;
  logic [TOT_W-1:0]  total;

  // Row start times pitch plus column; the address space wraps at the index width.
  assign row_base = PROD_W'(row_sum) * PROD_W'(pitch);
  assign total    = TOT_W'(row_base) + TOT_W'(col_sum);
  assign index    = total[IDX_W-1:0];

endmodule

[rtl/core/masked_alpha_blit_engine_core.sv]
// A result is offered once its pixel transfer has passed the input register, then the
// result register; the blend and both index multiply-adds sit between them.
// Throughput: one pixel per cycle, limited only by the result side stalling.
// Reset (synchronous, active high) empties both stages, clears the column and row
// counters and returns the registers to zero, with both pitches set to one.
module masked_alpha_blit_engine_core
  import mabe_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)
(
  input  logic                 clk,
  input  logic                 rst,

  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,

  // Pixel channel.
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [PIXEL_W-1:0]   source_pixel,
  input  logic [MASK_W-1:0]    mask_level,
  input  logic [PIXEL_W-1:0]   screen_pixel,

  // Result channel.
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [IDX_W-1:0]     source_index,
  output logic [IDX_W-1:0]     screen_index,
  output logic [PIXEL_W-1:0]   new_pixel,
  output logic                 write_enable,
  output logic                 last_pixel
);

  localparam int CNT_W    = $clog2(MAX_DIM);
  localparam int LIM_BITS = $clog2(MAX_DIM + 1);
  localparam int LIM_W    = (LIM_BITS > CFG_DIM_W) ? LIM_BITS : CFG_DIM_W;
  localparam int SUM_W    = ((CNT_W > COORD_W) ? CNT_W : COORD_W) + 1;

  // Configuration registers.
  logic [COORD_W-1:0]   src_x;
  logic [COORD_W-1:0]   src_y;
  logic [COORD_W-1:0]   dst_x;
  logic [COORD_W-1:0]   dst_y;
  logic [CFG_DIM_W-1:0] rect_width;
  logic [CFG_DIM_W-1:0] rect_height;
  logic [CFG_DIM_W-1:0] source_pitch;
  logic [CFG_DIM_W-1:0] screen_width;

  // Position within the rectangle.
  logic [CNT_W-1:0]     column_count;
  logic [CNT_W-1:0]     row_count;

  // Input stage.
  logic                 s1_valid;
  logic [PIXEL_W-1:0]   s1_source;
  logic [MASK_W-1:0]    s1_mask;
  logic [PIXEL_W-1:0]   s1_screen;
  logic [SUM_W-1:0]     s1_src_row;
  logic [SUM_W-1:0]     s1_src_col;
  logic [SUM_W-1:0]     s1_dst_row;
  logic [SUM_W-1:0]     s1_dst_col;
  logic                 s1_last;

  logic                 cfg_write;
  reg_idx_t             cfg_sel;
  logic                 s2_load;
  logic                 accept;
  logic [LIM_W-1:0]     width_lim;
  logic [LIM_W-1:0]     height_lim;
  logic                 empty_rect;
  logic [LIM_W-1:0]     col_inc;
  logic [LIM_W-1:0]     row_inc;
  logic                 row_end;
  logic                 rect_end;
  logic [IDX_W-1:0]     src_idx_calc;
  logic [IDX_W-1:0]     dst_idx_calc;
  logic [PIXEL_W-1:0]   pixel_calc;
  logic                 write_calc;

  // Configuration write and read decode.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_SRC_X:        prdata = DATA_W'(src_x);
      REG_SRC_Y:        prdata = DATA_W'(src_y);
      REG_DST_X:        prdata = DATA_W'(dst_x);
      REG_DST_Y:        prdata = DATA_W'(dst_y);
      REG_RECT_WIDTH:   prdata = DATA_W'(rect_width);
      REG_RECT_HEIGHT:  prdata = DATA_W'(rect_height);
      REG_SOURCE_PITCH: prdata = DATA_W'(source_pitch);
      REG_SCREEN_WIDTH: prdata = DATA_W'(screen_width);
      default:          prdata = '0;
    endcase
  end

  // Rectangle limits, clamped to the largest supported side.
  assign width_lim  = (LIM_W'(rect_width) > LIM_W'(MAX_DIM)) ?
                      LIM_W'(MAX_DIM) : LIM_W'(rect_width);
  assign height_lim = (LIM_W'(rect_height) > LIM_W'(MAX_DIM)) ?
                      LIM_W'(MAX_DIM) : LIM_W'(rect_height);
  assign empty_rect = (width_lim == '0) || (height_lim == '0);

  // End of row and end of rectangle for the pixel being taken.
  assign col_inc  = LIM_W'(column_count) + LIM_W'(1);
  assign row_inc  = LIM_W'(row_count) + LIM_W'(1);
  assign row_end  = col_inc >= width_lim;
  assign rect_end = row_end && (row_inc >= height_lim);

  // Pipeline flow: the result register loads when it is empty or its transfer completes.
  assign s2_load     = !result_valid || !result_stall;
  assign pixel_stall = s1_valid && !s2_load;
  assign accept      = pixel_valid && !pixel_stall;

  // Per-pixel work between the input stage and the result register.
  mabe_blend u_blend (
    .source_pixel (s1_source),
    .mask_level   (s1_mask),
    .screen_pixel (s1_screen),
    .new_pixel    (pixel_calc),
    .write_enable (write_calc)
  );

  mabe_index #(.SUM_W(SUM_W)) u_src_index (
    .row_sum (s1_src_row),
    .col_sum (s1_src_col),
    .pitch   (source_pitch),
    .index   (src_idx_calc)
  );

  mabe_index #(.SUM_W(SUM_W)) u_dst_index (
    .row_sum (s1_dst_row),
    .col_sum (s1_dst_col),
    .pitch   (screen_width),
    .index   (dst_idx_calc)
  );

  // Registers, counters and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_x        <= '0;
      src_y        <= '0;
      dst_x        <= '0;
      dst_y        <= '0;
      rect_width   <= '0;
      rect_height  <= '0;
      source_pitch <= CFG_DIM_W'(1);
      screen_width <= CFG_DIM_W'(1);
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Any register write restarts the rectangle.
      if (cfg_write) begin
        unique case (cfg_sel)
          REG_SRC_X:        src_x        <= pwdata[COORD_W-1:0];
          REG_SRC_Y:        src_y        <= pwdata[COORD_W-1:0];
          REG_DST_X:        dst_x        <= pwdata[COORD_W-1:0];
          REG_DST_Y:        dst_y        <= pwdata[COORD_W-1:0];
          REG_RECT_WIDTH:   rect_width   <= pwdata[CFG_DIM_W-1:0];
          REG_RECT_HEIGHT:  rect_height  <= pwdata[CFG_DIM_W-1:0];
          REG_SOURCE_PITCH: source_pitch <= pwdata[CFG_DIM_W-1:0];
          REG_SCREEN_WIDTH: screen_width <= pwdata[CFG_DIM_W-1:0];
          default:          src_x        <= src_x;
        endcase
        column_count <= '0;
        row_count    <= '0;
      end else if (accept && !empty_rect) begin
        if (rect_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (row_end) begin
          column_count <= '0;
          row_count    <= row_inc[CNT_W-1:0];
        end else begin
          column_count <= col_inc[CNT_W-1:0];
        end
      end

      // A pixel of an empty rectangle is taken and dropped.
      if (!s1_valid || s2_load) begin
        s1_valid <= accept && !empty_rect;
      end

      if (s2_load) begin
        result_valid <= s1_valid;
      end
    end
  end

  // Input stage payload, with row and column sums formed ahead of the multiply.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_source  <= source_pixel;
      s1_mask    <= mask_level;
      s1_screen  <= screen_pixel;
      s1_src_row <= SUM_W'(src_y) + SUM_W'(row_count);
      s1_src_col <= SUM_W'(src_x) + SUM_W'(column_count);
      s1_dst_row <= SUM_W'(dst_y) + SUM_W'(row_count);
      s1_dst_col <= SUM_W'(dst_x) + SUM_W'(column_count);
      s1_last    <= rect_end;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      source_index <= src_idx_calc;
      screen_index <= dst_idx_calc;
      new_pixel    <= pixel_calc;
      write_enable <= write_calc;
      last_pixel   <= s1_last;
    end
  end

endmodule
